FILE: rtl/udr_pkg.sv
// shared constants and result type for the 128-by-64 unsigned divider
package udr_pkg;

    localparam int FIELD_WIDTH        = 64;
    localparam int WORD_WIDTH_DEFAULT = 64;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] quotient;
        logic [FIELD_WIDTH-1:0] remainder;
        logic                   overflow_error;
    } result_t;

endpackage

FILE: rtl/udr_if.sv
// valid/ready channel interfaces for divider operands and results
interface udr_in_if
    import udr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] dividend_high;
    logic [FIELD_WIDTH-1:0] dividend_low;
    logic [FIELD_WIDTH-1:0] divisor;

    modport source (output valid, output dividend_high, output dividend_low,
                    output divisor, input ready);
    modport sink   (input valid, input dividend_high, input dividend_low,
                    input divisor, output ready);
endinterface

interface udr_out_if
    import udr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] quotient;
    logic [FIELD_WIDTH-1:0] remainder;
    logic                   overflow_error;

    modport source (output valid, output quotient, output remainder,
                    output overflow_error, input ready);
    modport sink   (input valid, input quotient, input remainder,
                    input overflow_error, output ready);
endinterface

FILE: rtl/udr_step.sv
// one restoring division step as a pipeline stage, one quotient bit per stage
module udr_step
    import udr_pkg::*;
#(
    parameter int W = WORD_WIDTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_rem,
    input  logic [W-1:0] in_lq,
    input  logic [W-1:0] in_div,
    input  logic         in_ovf,
    output logic         out_valid,
    output logic [W-1:0] out_rem,
    output logic [W-1:0] out_lq,
    output logic [W-1:0] out_div,
    output logic         out_ovf
);

    logic         valid_reg;
    logic [W-1:0] rem_reg;
    logic [W-1:0] rem_next;
    logic [W-1:0] lq_reg;
    logic [W-1:0] lq_next;
    logic [W-1:0] div_reg;
    logic         ovf_reg;
    logic [W-1:0] shifted;
    logic [W+1:0] diff;
    logic         take;

    // lq holds the unused dividend bits on top and the quotient bits below
    always_comb
    begin
        shifted  = {in_rem[W-2:0], in_lq[W-1]};
        diff     = {1'b0, in_rem[W-1], shifted} - {2'b00, in_div};
        take     = ~diff[W+1];
        rem_next = take ? diff[W-1:0] : shifted;
        lq_next  = {in_lq[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            div_reg <= in_div;
            ovf_reg <= in_ovf;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_lq    = lq_reg;
    assign out_div   = div_reg;
    assign out_ovf   = ovf_reg;

endmodule

FILE: rtl/udr_skid.sv
// output register with a skid entry that takes one more result under a stall before the pipeline holds
module udr_skid
    import udr_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           up_valid,
    input  result_t        up_data,
    output logic           up_ready,
    udr_out_if.source      dout
);

    logic    out_valid_reg;
    result_t out_data_reg;
    logic    skid_valid_reg;
    result_t skid_data_reg;
    logic    drain;

    assign up_ready = ~skid_valid_reg;
    assign drain    = dout.ready | ~out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (drain)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= up_valid;
            end
        end
        else if (up_valid && up_ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : up_data;
        end
        else if (up_valid && up_ready)
        begin
            skid_data_reg <= up_data;
        end
    end

    assign dout.valid          = out_valid_reg;
    assign dout.quotient       = out_data_reg.quotient;
    assign dout.remainder      = out_data_reg.remainder;
    assign dout.overflow_error = out_data_reg.overflow_error;

endmodule

FILE: rtl/udivrem_128_by_64.sv
// top level: pipelined unsigned double-word by single-word divider
// usage:
//   din carries dividend_high, dividend_low and divisor; dout returns
//   quotient, remainder and overflow_error, one result per operand transfer
//   in the same order. a transfer happens when valid and ready are both high.
//   only the low WORD_WIDTH bits of each operand are used.
//   overflow_error is set when dividend_high >= divisor (zero divisor too);
//   quotient and remainder are then zero.
// timing:
//   one operand register, WORD_WIDTH restoring steps (one quotient bit each,
//   one subtract and compare per stage) and one output register. a new
//   operand can be taken every cycle unless a stall holds the pipeline, so
//   throughput is one per cycle while dout keeps draining.
// reset:
//   rst_n clears all valid bits; nothing is in flight afterwards.
// stall:
//   a skid entry behind the output register takes one more result; then the
//   whole pipeline holds and din.ready drops until dout drains. nothing is
//   dropped or repeated.
module udivrem_128_by_64
    import udr_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    udr_in_if.sink    din,
    udr_out_if.source dout
);

    localparam int W = WORD_WIDTH;

    logic         en;
    logic         vld [0:W];
    logic [W-1:0] rem [0:W];
    logic [W-1:0] lq  [0:W];
    logic [W-1:0] dv  [0:W];
    logic         ovf [0:W];
    logic         in_valid_reg;
    logic [W-1:0] hi_reg;
    logic [W-1:0] lo_reg;
    logic [W-1:0] div_reg;
    logic         ovf_reg;
    logic         ovf_next;
    result_t      result;

    assign din.ready = en;
    assign ovf_next  = din.dividend_high[W-1:0] >= din.divisor[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg  <= din.dividend_high[W-1:0];
            lo_reg  <= din.dividend_low[W-1:0];
            div_reg <= din.divisor[W-1:0];
            ovf_reg <= ovf_next;
        end
    end

    assign vld[0] = in_valid_reg;
    assign rem[0] = hi_reg;
    assign lq[0]  = lo_reg;
    assign dv[0]  = div_reg;
    assign ovf[0] = ovf_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_step
        udr_step #(
            .W (W)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (vld[i]),
            .in_rem    (rem[i]),
            .in_lq     (lq[i]),
            .in_div    (dv[i]),
            .in_ovf    (ovf[i]),
            .out_valid (vld[i+1]),
            .out_rem   (rem[i+1]),
            .out_lq    (lq[i+1]),
            .out_div   (dv[i+1]),
            .out_ovf   (ovf[i+1])
        );
    end

    always_comb
    begin
        result.quotient       = ovf[W] ? '0 : FIELD_WIDTH'(lq[W]);
        result.remainder      = ovf[W] ? '0 : FIELD_WIDTH'(rem[W]);
        result.overflow_error = ovf[W];
    end

    udr_skid u_skid (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (vld[W]),
        .up_data  (result),
        .up_ready (en),
        .dout     (dout)
    );

endmodule

FILE: tb/sv/divrem_checker.sv
// checker: predicts each unsigned division and compares the results in order
`timescale 1ns / 1ps
module divrem_checker
    import udr_pkg::*;
#(
    parameter int WORD_WIDTH = WORD_WIDTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    udr_in_if         din,
    udr_out_if        dout,
    output int        fail_count,
    output int        pending,
    output int        result_count,
    output int        flagged_count
);

    localparam logic [FIELD_WIDTH-1:0] WORD_MASK =
        {FIELD_WIDTH{1'b1}} >> (FIELD_WIDTH - WORD_WIDTH);

    result_t expected_divrem[$];

    function automatic result_t predict_divrem(input logic [FIELD_WIDTH-1:0] hi_in,
                                               input logic [FIELD_WIDTH-1:0] lo_in,
                                               input logic [FIELD_WIDTH-1:0] div_in);
        logic [FIELD_WIDTH-1:0]   hi;
        logic [FIELD_WIDTH-1:0]   lo;
        logic [FIELD_WIDTH-1:0]   d;
        logic [2*FIELD_WIDTH-1:0] dividend;
        logic [2*FIELD_WIDTH-1:0] wide_div;
        result_t                  r;
        hi = hi_in & WORD_MASK;
        lo = lo_in & WORD_MASK;
        d  = div_in & WORD_MASK;
        r  = '0;
        // quotient would not fit a word, zero divisor lands here too
        if (hi >= d) begin
            r.overflow_error = 1'b1;
        end
        else begin
            wide_div   = {{FIELD_WIDTH{1'b0}}, d};
            dividend   = ({{FIELD_WIDTH{1'b0}}, hi} << WORD_WIDTH) | {{FIELD_WIDTH{1'b0}}, lo};
            r.quotient  = FIELD_WIDTH'(dividend / wide_div);
            r.remainder = FIELD_WIDTH'(dividend % wide_div);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        int      errs;
        if (!rst_n) begin
            expected_divrem.delete();
            fail_count    <= 0;
            pending       <= 0;
            result_count  <= 0;
            flagged_count <= 0;
        end
        else begin
            errs = 0;
            if (din.valid && din.ready) begin
                expected_divrem.push_back(predict_divrem(din.dividend_high, din.dividend_low,
                                                         din.divisor));
            end
            if (dout.valid && dout.ready) begin
                result_count <= result_count + 1;
                if (dout.overflow_error === 1'b1) begin
                    flagged_count <= flagged_count + 1;
                end
                if (expected_divrem.size() == 0) begin
                    $display("%0t: unexpected result q=%h r=%h ovf=%b", $time,
                             dout.quotient, dout.remainder, dout.overflow_error);
                    errs++;
                end
                else begin
                    want = expected_divrem.pop_front();
                    if (dout.quotient !== want.quotient) begin
                        $display("%0t: quotient mismatch expected %h actual %h", $time,
                                 want.quotient, dout.quotient);
                        errs++;
                    end
                    if (dout.remainder !== want.remainder) begin
                        $display("%0t: remainder mismatch expected %h actual %h", $time,
                                 want.remainder, dout.remainder);
                        errs++;
                    end
                    if (dout.overflow_error !== want.overflow_error) begin
                        $display("%0t: overflow_error mismatch expected %b actual %b", $time,
                                 want.overflow_error, dout.overflow_error);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
            pending    <= expected_divrem.size();
        end
    end

endmodule

FILE: tb/sv/tb_udivrem_128_by_64.sv
// testbench top: drives operands and result back-pressure, gives the verdict
`timescale 1ns / 1ps
module tb_udivrem_128_by_64;
    import udr_pkg::*;

    localparam int WORD_WIDTH   = WORD_WIDTH_DEFAULT;
    localparam int RANDOM_ITEMS = 530;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [FIELD_WIDTH-1:0] ALL_ONES = '1;
    localparam logic [FIELD_WIDTH-1:0] TOP_BIT  = {1'b1, {(FIELD_WIDTH-1){1'b0}}};

    logic clk;
    logic rst_n;
    bit   bursting;
    int   fail_count;
    int   pending;
    int   result_count;
    int   flagged_count;
    int   items_sent    = 0;
    int   zero_divisors = 0;
    int   directed_cnt  = 0;
    int   cycle_count   = 0;

    udr_in_if  in_ch ();
    udr_out_if out_ch ();

    udivrem_128_by_64 #(
        .WORD_WIDTH(WORD_WIDTH)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .din  (in_ch),
        .dout (out_ch)
    );

    divrem_checker #(
        .WORD_WIDTH(WORD_WIDTH)
    ) u_divrem_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .din          (in_ch),
        .dout         (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .flagged_count(flagged_count)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAIL");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end
        else if (pick < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    function automatic logic [FIELD_WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_division(input logic [FIELD_WIDTH-1:0] hi,
                                 input logic [FIELD_WIDTH-1:0] lo,
                                 input logic [FIELD_WIDTH-1:0] d);
        int gap;
        gap = bursting ? 0 : idle_len();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.dividend_high <= hi;
        in_ch.dividend_low  <= lo;
        in_ch.divisor       <= d;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
        if (d == '0) begin
            zero_divisors++;
        end
    endtask

    task automatic send_random();
        logic [FIELD_WIDTH-1:0] hi;
        logic [FIELD_WIDTH-1:0] lo;
        logic [FIELD_WIDTH-1:0] d;
        int                     kind;
        kind = $urandom_range(0, 99);
        lo   = rand_word();
        d    = rand_word() >> (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 63));
        if (kind < 82) begin
            // quotient fits: high word below the divisor
            if (d == '0) begin
                d = 1;
            end
            hi = ($urandom_range(0, 3) == 0) ? d - 1 : rand_word() % d;
        end
        else if (kind < 95) begin
            hi = d + (rand_word() >> $urandom_range(0, 63));
            if (hi < d) begin
                hi = ALL_ONES;
            end
        end
        else begin
            d  = '0;
            hi = rand_word() >> $urandom_range(0, 63);
        end
        send_division(hi, lo, d);
    endtask

    task automatic send_directed();
        send_division('0, '0, 64'd1);
        send_division('0, ALL_ONES, 64'd1);
        send_division('0, ALL_ONES, ALL_ONES);
        send_division(ALL_ONES - 1, ALL_ONES, ALL_ONES);
        send_division(ALL_ONES - 1, '0, ALL_ONES);
        send_division('0, 64'd5, 64'd7);
        send_division(TOP_BIT - 1, ALL_ONES, TOP_BIT);
        send_division(TOP_BIT, ALL_ONES, TOP_BIT + 1);
        send_division(64'h1234_5678_9abc_def0, 64'h0fed_cba9_8765_4321, 64'hffff_0000_ffff_0001);
        send_division(64'd2, 64'd3, 64'd3);
        // zero divisor
        send_division('0, '0, '0);
        send_division(ALL_ONES, ALL_ONES, '0);
        send_division('0, ALL_ONES, '0);
        // high word equal to or above the divisor
        send_division(ALL_ONES, ALL_ONES, ALL_ONES);
        send_division(64'd1, '0, 64'd1);
        send_division(64'd5, 64'd9, 64'd3);
        send_division(ALL_ONES, '0, 64'd1);
        send_division(TOP_BIT, '0, TOP_BIT);
        directed_cnt = items_sent;
    endtask

    // result side back-pressure
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            if (!bursting) begin
                stall = idle_len();
                if (stall > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    initial begin
        rst_n               = 1'b0;
        bursting            = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.dividend_high = '0;
        in_ch.dividend_low  = '0;
        in_ch.divisor       = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_directed();
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            // full-rate stretches on both channels
            bursting = (i >= 120 && i < 200) || (i >= 420 && i < 460);
            if (i == 300) begin
                in_ch.valid <= 1'b0;
                while (pending != 0) @(negedge clk);
            end
            send_random();
        end
        bursting = 1'b0;
        in_ch.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (WORD_WIDTH + 8) @(negedge clk);

        $display("covered %0d divisions (%0d directed), %0d results, %0d flagged, %0d zero divisors",
                 items_sent, directed_cnt, result_count, flagged_count, zero_divisors);
        $display("stalls on both channels, full-rate bursts and one full drain mid-run");
        if (fail_count == 0) begin
            $display("PASS");
        end
        else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/udr_pkg.sv
rtl/udr_if.sv
rtl/udr_step.sv
rtl/udr_skid.sv
rtl/udivrem_128_by_64.sv
tb/sv/divrem_checker.sv
tb/sv/tb_udivrem_128_by_64.sv
